[rtl/assert_macros.svh]
// Assertion macros shared by the filter modules.
// Depends on nothing; the bodies vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/maf_pkg.sv]
// Shared types and constants of the moving average filter.
// Depends on nothing; used by every module of the filter but the RAM.
`timescale 1ns / 1ps
package maf_pkg;

    // Width of the window length register on the configuration port.
    localparam int CFG_W = 9;
    // Window length after reset, before clamping to the ring size.
    localparam int LEN_RESET_VAL = 16;
    // Entries of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    // Input action codes.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Status of the decoupling queue as seen by its two sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Front end: waiting for an item, or carrying one out.
    typedef enum logic {
        FE_IDLE,
        FE_EXEC
    } fe_state_t;

    // Back end: waiting for an entry, dividing, or handing over the result.
    typedef enum logic [1:0] {
        BE_IDLE,
        BE_DIV,
        BE_DONE
    } be_state_t;

endpackage

[rtl/moving_average_filter.sv]
// Boxcar moving average: front end keeps ring and running sum, back end divides.
// The front end takes one item at a time, holding it in its execute state until the queue
// takes the entry; a two-entry queue lets it accept further items while the bit-serial
// divider works on earlier ones, so the divider sets the sustained rate of results.
// Reset: rst_n clears control state asynchronously; window length returns to 16, ring empty.
`timescale 1ns / 1ps
module moving_average_filter #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          action,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] average,
    output logic                          window_full,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [maf_pkg::CFG_W-1:0]     window_length
);
    import maf_pkg::*;

    localparam int ENTRY_W = SAMPLE_BITS + $clog2(WINDOW_MAX) + $clog2(WINDOW_MAX + 1) + 1;

    q_stat_t            q_stat;
    logic               q_wr, q_rd;
    logic [ENTRY_W-1:0] q_wr_data, q_rd_data;

    // Item intake, ring and running sum.
    maf_front #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .sample        (sample),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length),
        .q_stat        (q_stat),
        .q_wr          (q_wr),
        .q_data        (q_wr_data)
    );

    // Decoupling queue of sums, fill counts and window-full flags.
    maf_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wr_data),
        .rd_en   (q_rd),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    // Division and result register.
    maf_back #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .q_rd        (q_rd),
        .q_data      (q_rd_data),
        .empty       (empty),
        .pop         (pop),
        .average     (average),
        .window_full (window_full)
    );

endmodule

[rtl/maf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/maf_queue.sv]
// Small register queue that decouples the front end from the divider.
// Depends on maf_pkg for the status struct.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module maf_queue #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output maf_pkg::q_stat_t stat
);
    import maf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    // Status and the effective transfers.
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = slot_reg[rd_ptr_reg];

    // Pointer and count updates, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // The count never passes the depth.
    `ASSERT_PROP(a_cnt_bounded, clk, rst_n, cnt_reg <= CNT_W'(DEPTH))

endmodule

[rtl/maf_front.sv]
// Front end: accepts items, keeps the sample ring, fill count and running sum.
// Depends on maf_pkg and the maf_ram instance for the ring.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module maf_front #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       push,
    output logic                                       full,
    input  logic                                       action,
    input  logic signed [SAMPLE_BITS-1:0]              sample,
    input  logic                                       cfg_valid,
    output logic                                       cfg_ready,
    input  logic [maf_pkg::CFG_W-1:0]                  window_length,
    input  maf_pkg::q_stat_t                           q_stat,
    output logic                                       q_wr,
    output logic [SAMPLE_BITS + $clog2(WINDOW_MAX) + $clog2(WINDOW_MAX + 1):0] q_data
);
    import maf_pkg::*;

    localparam int PTR_W     = $clog2(WINDOW_MAX);
    localparam int LEN_W     = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W     = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int LEN_RESET = (LEN_RESET_VAL > WINDOW_MAX) ? WINDOW_MAX : LEN_RESET_VAL;
    localparam int ENTRY_W   = 1 + LEN_W + SUM_W;

    fe_state_t                state_reg, state_next;
    logic                     act_reg;
    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic [LEN_W-1:0]         len_reg, len_cfg;
    logic [PTR_W-1:0]         pos_reg, pos_next;
    logic [LEN_W-1:0]         fill_reg, fill_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0]   old_raw;
    logic [LEN_W-1:0]         pos_inc;
    logic                     accept, commit, cfg_wr;
    logic                     ring_full_next;
    logic [ENTRY_W-1:0]       entry;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Clamp a written window length to the range one to the ring size.
    always_comb
    begin
        if (window_length == '0)
        begin
            len_cfg = LEN_W'(1);
        end
        else if (32'(window_length) > 32'(WINDOW_MAX))
        begin
            len_cfg = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len_cfg = LEN_W'(window_length);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE:
            begin
                if (push)
                begin
                    state_next = FE_EXEC;
                end
            end
            FE_EXEC:
            begin
                if (!q_stat.full)
                begin
                    state_next = FE_IDLE;
                end
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        full   = 1'b1;
        accept = 1'b0;
        commit = 1'b0;
        case (state_reg)
            FE_IDLE:
            begin
                full   = 1'b0;
                accept = push;
            end
            FE_EXEC:
            begin
                commit = !q_stat.full;
            end
            default:
            begin
                full = 1'b1;
            end
        endcase
    end

    // Ring, count and sum update for the item held in the execute slot.
    always_comb
    begin
        pos_inc   = LEN_W'(pos_reg) + LEN_W'(1);
        pos_next  = (pos_inc >= len_reg) ? '0 : PTR_W'(pos_inc);
        fill_next = fill_reg;
        sum_next  = sum_reg + SUM_W'(smp_reg);
        if (act_reg == ACT_CLEAR)
        begin
            pos_next  = '0;
            fill_next = '0;
            sum_next  = '0;
        end
        else if (fill_reg >= len_reg)
        begin
            // Window full: the oldest sample leaves as the new one comes in.
            sum_next = sum_reg - SUM_W'($signed(old_raw)) + SUM_W'(smp_reg);
        end
        else
        begin
            fill_next = fill_reg + 1'b1;
        end
        ring_full_next = (act_reg == ACT_ADD) && (fill_next >= len_reg);
        entry          = {ring_full_next, fill_next, sum_next};
    end

    assign q_wr   = commit;
    assign q_data = entry;

    // Sample ring; the read address follows the write position.
    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk     (clk),
        .wr_en   (commit && (act_reg == ACT_ADD)),
        .wr_addr (pos_reg),
        .wr_data (smp_reg),
        .rd_addr (pos_reg),
        .rd_data (old_raw)
    );

    // Control state and running sum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
            len_reg   <= LEN_W'(LEN_RESET);
            pos_reg   <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                len_reg  <= len_cfg;
                pos_reg  <= '0;
                fill_reg <= '0;
                sum_reg  <= '0;
            end
            else if (commit)
            begin
                pos_reg  <= pos_next;
                fill_reg <= fill_next;
                sum_reg  <= sum_next;
            end
        end
    end

    // Item held while it is carried out.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= action;
            smp_reg <= sample;
        end
    end

    // The ring never holds more than a window, and the position stays inside it.
    `ASSERT_PROP(a_fill_in_window, clk, rst_n, fill_reg <= len_reg)
    `ASSERT_PROP(a_pos_in_window, clk, rst_n, LEN_W'(pos_reg) < len_reg)

endmodule

[rtl/maf_back.sv]
// Back end: divides the running sum by the fill count, one quotient bit a cycle.
// Depends on maf_pkg; holds the output register of the result side.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module maf_back #(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  maf_pkg::q_stat_t                           q_stat,
    output logic                                       q_rd,
    input  logic [SAMPLE_BITS + $clog2(WINDOW_MAX) + $clog2(WINDOW_MAX + 1):0] q_data,
    output logic                                       empty,
    input  logic                                       pop,
    output logic signed [SAMPLE_BITS-1:0]              average,
    output logic                                       window_full
);
    import maf_pkg::*;

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(SUM_W + 1);

    be_state_t              state_reg, state_next;
    logic                   neg_reg, full_reg;
    logic [LEN_W-1:0]       div_reg;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]       quo_reg, quo_next;
    logic [CNT_W-1:0]       cnt_reg;
    logic [LEN_W:0]         rem_sh;
    logic signed [SUM_W-1:0] q_sum;
    logic [SUM_W-1:0]       q_mag;
    logic                   step, load_out, slot_free;
    logic                   out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] avg_reg, avg_next;
    logic                   wfull_reg;

    assign q_sum     = q_data[SUM_W-1:0];
    assign q_mag     = q_sum[SUM_W-1] ? SUM_W'(-q_sum) : SUM_W'(q_sum);
    assign slot_free = !out_valid_reg || pop;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BE_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = BE_DIV;
                end
            end
            BE_DIV:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = BE_DONE;
                end
            end
            BE_DONE:
            begin
                if (slot_free)
                begin
                    state_next = BE_IDLE;
                end
            end
            default:
            begin
                state_next = BE_IDLE;
            end
        endcase
    end

    // Control outputs of the divider sequencer.
    always_comb
    begin
        q_rd     = 1'b0;
        step     = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            BE_IDLE:
            begin
                q_rd = !q_stat.empty;
            end
            BE_DIV:
            begin
                step = 1'b1;
            end
            BE_DONE:
            begin
                load_out = slot_free;
            end
            default:
            begin
                q_rd = 1'b0;
            end
        endcase
    end

    // One restoring division step; the quotient shifts in where the dividend leaves.
    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[SUM_W-1]};
        if (rem_sh >= {1'b0, div_reg})
        begin
            rem_next = LEN_W'(rem_sh - {1'b0, div_reg});
            quo_next = {quo_reg[SUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = LEN_W'(rem_sh);
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
        end
    end

    // Signed result, zero for an empty window.
    always_comb
    begin
        if (div_reg == '0)
        begin
            avg_next = '0;
        end
        else if (neg_reg)
        begin
            avg_next = SAMPLE_BITS'(~quo_reg + 1'b1);
        end
        else
        begin
            avg_next = SAMPLE_BITS'(quo_reg);
        end
    end

    // Sequencer and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BE_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_rd)
            begin
                cnt_reg <= CNT_W'(SUM_W);
            end
            else if (step)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider operands and result register.
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            neg_reg  <= q_sum[SUM_W-1];
            full_reg <= q_data[SUM_W+LEN_W];
            div_reg  <= q_data[SUM_W+LEN_W-1:SUM_W];
            rem_reg  <= '0;
            quo_reg  <= q_mag;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (load_out)
        begin
            avg_reg   <= avg_next;
            wfull_reg <= full_reg;
        end
    end

    assign empty       = !out_valid_reg;
    assign average     = avg_reg;
    assign window_full = wfull_reg;

    // A finished non-negative quotient of a non-empty window fits the sample range.
    `ASSERT_PROP(a_quo_fits, clk, rst_n,
        (state_reg == BE_DONE && div_reg != '0 && !neg_reg) |->
        (quo_reg[SUM_W-1:SAMPLE_BITS-1] == '0))
    // The result is handed over only once the division steps have run.
    `ASSERT_PROP(a_done_after_div, clk, rst_n,
        (state_reg == BE_DONE) |-> ($past(state_reg) == BE_DIV || $past(state_reg) == BE_DONE))

endmodule

[test/tb_moving_average_filter.sv]
// Self-checking testbench for the boxcar moving average filter.
// Depends on maf_pkg and moving_average_filter; predicts every result internally.
`timescale 1ns / 1ps
module tb_moving_average_filter;

    import maf_pkg::*;

    localparam int WIN_MAX        = 256;
    localparam int SMP_W          = 16;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_PHASES       = 12;

    // Sample mix used by a random phase.
    typedef enum int {
        MIX_GENERAL,
        MIX_HIGH,
        MIX_LOW
    } sample_mix_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] average;
        logic                    window_full;
    } avg_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic                    action;
    logic signed [SMP_W-1:0] sample;
    logic                    empty;
    logic                    pop;
    logic signed [SMP_W-1:0] average;
    logic                    window_full;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        window_length;

    // Model of the filter state.
    logic signed [SMP_W-1:0] ring_model [WIN_MAX];
    int unsigned             model_pos;
    int unsigned             model_fill;
    int unsigned             model_len;
    longint                  model_sum;

    avg_result_t             expected_results [$];
    int                      error_count;
    int                      items_sent;
    int                      results_checked;
    int                      length_writes;
    bit                      send_idle;
    bit                      recv_idle;
    int                      hold_request;
    int                      idle_cycles;

    moving_average_filter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .action        (action),
        .sample        (sample),
        .empty         (empty),
        .pop           (pop),
        .average       (average),
        .window_full   (window_full),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .window_length (window_length)
    );

    // Free-running clock, 8 ns period.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Empty the modelled ring and zero its sum.
    function automatic void empty_model();
        model_pos  = 0;
        model_fill = 0;
        model_sum  = 0;
    endfunction

    // A length write clamps to 1..WIN_MAX and also empties the ring.
    function automatic void apply_length(input logic [CFG_W-1:0] len);
        if (len == 0)
            model_len = 1;
        else if (len > WIN_MAX)
            model_len = WIN_MAX;
        else
            model_len = len;
        empty_model();
    endfunction

    // Work out the average and fill flag that one accepted item yields.
    function automatic avg_result_t filter_predict(input logic act,
                                                   input logic signed [SMP_W-1:0] smp);
        avg_result_t r;
        int unsigned pos;
        longint      quot;
        if (act == ACT_CLEAR)
        begin
            empty_model();
            r.average     = '0;
            r.window_full = 1'b0;
            return r;
        end
        pos = model_pos;
        if (pos >= model_len)
            pos = 0;
        // Once full, the oldest sample leaves the sum before its slot is reused.
        if (model_fill >= model_len)
            model_sum -= ring_model[pos];
        else
            model_fill++;
        ring_model[pos] = smp;
        model_sum += smp;
        pos++;
        if (pos >= model_len)
            pos = 0;
        model_pos = pos;
        quot = model_sum / longint'(model_fill);
        r.average     = quot[SMP_W-1:0];
        r.window_full = (model_fill >= model_len);
        return r;
    endfunction

    // Offer one item after a random gap and record its expected result on acceptance.
    task automatic send_item(input logic act, input logic signed [SMP_W-1:0] smp);
        int gap;
        gap = send_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push   <= 1'b1;
        action <= act;
        sample <= smp;
        do
            @(posedge clk);
        while (full);
        expected_results.push_back(filter_predict(act, smp));
        items_sent++;
    endtask

    // Wait until every expected result has been checked and the block has settled.
    task automatic wait_idle();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the window length while the block is idle.
    task automatic write_window_length(input logic [CFG_W-1:0] len);
        wait_idle();
        cfg_valid     <= 1'b1;
        window_length <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_length(len);
        length_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Draw a sample according to the phase's mix.
    function automatic logic signed [SMP_W-1:0] draw_sample(input sample_mix_t mix);
        int sel;
        logic [31:0] raw;
        sel = $urandom_range(0, 9);
        raw = $urandom();
        if (mix == MIX_HIGH)
            return (sel != 0) ? 16'sh7fff : raw[SMP_W-1:0];
        if (mix == MIX_LOW)
            return (sel != 0) ? 16'sh8000 : raw[SMP_W-1:0];
        case (sel)
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return SMP_W'($urandom_range(0, 8)) - 16'sd4;
            default: return raw[SMP_W-1:0];
        endcase
    endfunction

    // Full-scale samples at the default length, with truncation of small negative sums.
    task automatic test_extremes();
        send_item(ACT_ADD, 16'sh7fff);
        send_item(ACT_ADD, 16'sh7fff);
        send_item(ACT_ADD, 16'sh8000);
        send_item(ACT_ADD, 16'sh8000);
        send_item(ACT_ADD, -16'sd1);
        send_item(ACT_ADD, 16'sd1);
        send_item(ACT_ADD, 16'sd0);
    endtask

    // Clear on a partly filled ring, clear on an empty ring, then a single sample and a clear.
    task automatic test_clear();
        send_item(ACT_CLEAR, 16'sh7fff);
        send_item(ACT_CLEAR, 16'sh0000);
        send_item(ACT_ADD, 16'sh8000);
        send_item(ACT_CLEAR, 16'sh8000);
    endtask

    // A zero length behaves as a window of one sample.
    task automatic test_zero_length();
        write_window_length('0);
        send_item(ACT_ADD, 16'sd5);
        send_item(ACT_ADD, -16'sd7);
        send_item(ACT_CLEAR, 16'sd0);
        send_item(ACT_ADD, 16'sh7fff);
    endtask

    // A length above the ring size saturates to the ring size.
    task automatic test_oversized_length();
        write_window_length(9'd300);
        send_item(ACT_ADD, 16'sh1234);
        send_item(ACT_ADD, -16'sh4321);
        send_item(ACT_ADD, 16'sh8000);
    endtask

    // Writing the length empties the ring, even when the value is unchanged.
    task automatic test_length_write_flush();
        write_window_length(9'd2);
        send_item(ACT_ADD, 16'sd100);
        send_item(ACT_ADD, 16'sd200);
        send_item(ACT_ADD, 16'sd300);
        write_window_length(9'd2);
        send_item(ACT_ADD, 16'sd4);
    endtask

    // Hold the output off for a long stretch while items keep arriving back to back.
    task automatic test_backpressure();
        send_idle    = 1'b0;
        hold_request = 400;
        repeat (40)
            send_item(($urandom_range(0, 19) == 0) ? ACT_CLEAR : ACT_ADD,
                      draw_sample(MIX_GENERAL));
        send_idle = 1'b1;
    endtask

    // Random phases over a spread of window lengths, sample mixes and idling.
    task automatic test_random();
        int          lens   [N_PHASES] = '{1, 2, 5, 16, 33, 256, 255, 511, 0, 3, -1, -1};
        int          counts [N_PHASES] = '{80, 80, 80, 100, 100, 320, 300, 280, 60, 60,
                                           100, 100};
        sample_mix_t mixes  [N_PHASES] = '{MIX_GENERAL, MIX_GENERAL, MIX_GENERAL,
                                           MIX_GENERAL, MIX_GENERAL, MIX_HIGH,
                                           MIX_GENERAL, MIX_LOW, MIX_GENERAL,
                                           MIX_GENERAL, MIX_GENERAL, MIX_GENERAL};
        int          len;
        int          clear_permille;
        logic        act;
        for (int p = 0; p < N_PHASES; p++)
        begin
            len = (lens[p] < 0) ? $urandom_range(1, 64) : lens[p];
            write_window_length(len[CFG_W-1:0]);
            // Long windows only fill if clears are rare.
            clear_permille = (len >= 128) ? 2 : 30;
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < counts[p]; i++)
            begin
                act = ($urandom_range(0, 999) < clear_permille) ? ACT_CLEAR : ACT_ADD;
                send_item(act, draw_sample(mixes[p]));
            end
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // Stimulus: reset, directed tests, back-pressure, random phases, then the verdict.
    initial
    begin
        error_count     = 0;
        items_sent      = 0;
        results_checked = 0;
        length_writes   = 0;
        send_idle       = 1'b1;
        recv_idle       = 1'b1;
        hold_request    = 0;
        rst_n          <= 1'b0;
        push           <= 1'b0;
        action         <= ACT_ADD;
        sample         <= '0;
        cfg_valid      <= 1'b0;
        window_length  <= '0;
        apply_length(CFG_W'(LEN_RESET_VAL));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_clear();
        test_zero_length();
        test_oversized_length();
        test_length_write_flush();
        wait_idle();
        test_backpressure();
        test_random();
        wait_idle();

        $display("Summary: %0d items sent, %0d results checked, %0d window length writes.",
                 items_sent, results_checked, length_writes);
        $display("Covered clears, length writes, windows of 1 to 256 and a long output stall.");
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side: random pop gaps, an occasional long hold, and a field-by-field check.
    initial
    begin : result_checker
        avg_result_t exp_r;
        int          wait_cycles;
        pop <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                wait_cycles  = hold_request;
                hold_request = 0;
            end
            else
                wait_cycles = recv_idle ? $urandom_range(0, 17) : 0;
            if (wait_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            results_checked++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: average %0d, window_full %0b", average, window_full);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (average !== exp_r.average)
                begin
                    $error("average mismatch: expected %0d, actual %0d", exp_r.average, average);
                    error_count++;
                end
                if (window_full !== exp_r.window_full)
                begin
                    $error("window_full mismatch: expected %0b, actual %0b",
                           exp_r.window_full, window_full);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no handshake completes for too long.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule
